[src/nfz4_pkg.sv]
// Shared types, constants and saturating helpers for the z^4-1 Newton pixel core.
`default_nettype none
package nfz4_pkg;

    localparam int FRAC_BITS_DEF = 28;
    localparam int IFRAC         = 56;

    localparam logic signed [63:0] ONE_Q = 64'sh0100_0000_0000_0000;
    localparam logic signed [63:0] SMAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] SMIN  = 64'sh8000_0000_0000_0000;

    localparam logic [7:0]  LIMIT_RST = 8'd50;
    localparam logic [31:0] CONV_RST  = 32'd16;
    localparam logic [31:0] TOL_RST   = 32'd16;

    localparam logic [4:0] PC_EVAL = 5'd0;
    localparam logic [4:0] PC_NUM  = 5'd12;
    localparam logic [4:0] PC_NORM = 5'd18;
    localparam logic [4:0] PC_ROOT = 5'd20;

    typedef enum logic [1:0] {
        CFG_LIMIT = 2'd0,
        CFG_CONV  = 2'd1,
        CFG_TOL   = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0]  limit;
        logic [31:0] conv;
        logic [31:0] tol;
    } t_cfg;

    typedef struct packed {
        logic signed [63:0] re;
        logic signed [63:0] im;
    } t_pt;

    typedef struct packed {
        logic [1:0] root_index;
        logic       found;
        logic [7:0] iteration_count;
    } t_res;

    typedef enum logic [3:0] {
        OP_ZR, OP_ZI, OP_Z2R, OP_Z2I, OP_Z3R, OP_Z3I,
        OP_FR, OP_FI, OP_DR, OP_DI, OP_ER, OP_EI
    } t_opnd;

    typedef enum logic [1:0] {ACC_LOAD, ACC_ADD, ACC_SUB} t_accop;

    typedef enum logic [3:0] {
        WB_NONE, WB_Z2R, WB_Z2I, WB_Z3R, WB_Z3I, WB_FR, WB_FI, WB_DEN, WB_NR, WB_NI
    } t_wb;

    typedef struct packed {
        t_opnd  a;
        t_opnd  b;
        t_accop op;
        t_wb    wb;
        logic   last;
    } t_uop;

    typedef enum logic [3:0] {
        S_IDLE, S_EVAL1, S_CHECK, S_NUM, S_DIV, S_EVAL2,
        S_NORM, S_NCHK, S_RSUB, S_ROOT, S_RCHK, S_DONE
    } t_state;

    function automatic logic signed [63:0] sat65(input logic signed [64:0] w);
        if (w[64] == w[63]) return w[63:0];
        return w[64] ? SMIN : SMAX;
    endfunction

    function automatic logic signed [63:0] s_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
        logic signed [64:0] w;
        w = {a[63], a} + {b[63], b};
        return sat65(w);
    endfunction

    function automatic logic signed [63:0] s_sub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
        logic signed [64:0] w;
        w = {a[63], a} - {b[63], b};
        return sat65(w);
    endfunction

    // arithmetic shift right by 56, then clamp to 64 bits
    function automatic logic signed [63:0] sat_q56(input logic [127:0] a);
        if ((&a[127:119]) || (~|a[127:119])) return a[119:56];
        return a[127] ? SMIN : SMAX;
    endfunction

    function automatic logic signed [63:0] sat_x4(input logic signed [63:0] z);
        logic [65:0] w;
        w = {z[63], z[63], z} << 2;
        if ((&w[65:63]) || (~|w[65:63])) return w[63:0];
        return z[63] ? SMIN : SMAX;
    endfunction

    function automatic logic signed [63:0] root_re(input logic [1:0] k);
        case (k)
            2'd0:    return ONE_Q;
            2'd1:    return -ONE_Q;
            default: return 64'sd0;
        endcase
    endfunction

    function automatic logic signed [63:0] root_im(input logic [1:0] k);
        case (k)
            2'd2:    return ONE_Q;
            2'd3:    return -ONE_Q;
            default: return 64'sd0;
        endcase
    endfunction

    // multiply program: eval z^2, z^3, z^4; |f'|^2 and Newton numerators; |f|^2; root distance
    function automatic t_uop uop_rom(input logic [4:0] pc);
        t_uop u;
        case (pc)
            5'd0:  u = '{OP_ZR,  OP_ZR, ACC_LOAD, WB_NONE, 1'b0};
            5'd1:  u = '{OP_ZI,  OP_ZI, ACC_SUB,  WB_Z2R,  1'b0};
            5'd2:  u = '{OP_ZR,  OP_ZI, ACC_LOAD, WB_NONE, 1'b0};
            5'd3:  u = '{OP_ZI,  OP_ZR, ACC_ADD,  WB_Z2I,  1'b0};
            5'd4:  u = '{OP_Z2R, OP_ZR, ACC_LOAD, WB_NONE, 1'b0};
            5'd5:  u = '{OP_Z2I, OP_ZI, ACC_SUB,  WB_Z3R,  1'b0};
            5'd6:  u = '{OP_Z2R, OP_ZI, ACC_LOAD, WB_NONE, 1'b0};
            5'd7:  u = '{OP_Z2I, OP_ZR, ACC_ADD,  WB_Z3I,  1'b0};
            5'd8:  u = '{OP_Z3R, OP_ZR, ACC_LOAD, WB_NONE, 1'b0};
            5'd9:  u = '{OP_Z3I, OP_ZI, ACC_SUB,  WB_FR,   1'b0};
            5'd10: u = '{OP_Z3R, OP_ZI, ACC_LOAD, WB_NONE, 1'b0};
            5'd11: u = '{OP_Z3I, OP_ZR, ACC_ADD,  WB_FI,   1'b1};
            5'd12: u = '{OP_DR,  OP_DR, ACC_LOAD, WB_NONE, 1'b0};
            5'd13: u = '{OP_DI,  OP_DI, ACC_ADD,  WB_DEN,  1'b0};
            5'd14: u = '{OP_FR,  OP_DR, ACC_LOAD, WB_NONE, 1'b0};
            5'd15: u = '{OP_FI,  OP_DI, ACC_ADD,  WB_NR,   1'b0};
            5'd16: u = '{OP_FI,  OP_DR, ACC_LOAD, WB_NONE, 1'b0};
            5'd17: u = '{OP_FR,  OP_DI, ACC_SUB,  WB_NI,   1'b1};
            5'd18: u = '{OP_FR,  OP_FR, ACC_LOAD, WB_NONE, 1'b0};
            5'd19: u = '{OP_FI,  OP_FI, ACC_ADD,  WB_NONE, 1'b1};
            5'd20: u = '{OP_ER,  OP_ER, ACC_LOAD, WB_NONE, 1'b0};
            5'd21: u = '{OP_EI,  OP_EI, ACC_ADD,  WB_NONE, 1'b1};
            default: u = '{OP_ZR, OP_ZR, ACC_LOAD, WB_NONE, 1'b1};
        endcase
        return u;
    endfunction

endpackage
`default_nettype wire

[src/nfz4_front.sv]
// Front end: accepts start points, converts them to Q7.56 and queues them.
`default_nettype none
module nfz4_front
    import nfz4_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    output logic                    o_full,
    input  wire logic signed [31:0] i_start_re,
    input  wire logic signed [31:0] i_start_im,
    output logic                    o_valid,
    output t_pt                     o_pt,
    input  wire logic               i_pop
);
    localparam int SH = IFRAC - FRAC_BITS;

    function automatic logic signed [63:0] widen(input logic signed [31:0] x);
        logic [95:0] w;
        w = {{64{x[31]}}, x} << SH;
        if ((&w[95:63]) || (~|w[95:63])) return w[63:0];
        return x[31] ? SMIN : SMAX;
    endfunction

    t_pt        r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       push_ok;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_pt    = r_mem[r_rd];
    assign push_ok = i_push && !o_full;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= '{re: widen(i_start_re), im: widen(i_start_im)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push_ok) r_wr <= ~r_wr;
            if (i_pop)   r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, push_ok} - {1'b0, i_pop};
        end
    end
endmodule
`default_nettype wire

[src/nfz4_mul.sv]
// Signed 64x64 exact multiplier built from four 32x32 partial products.
`default_nettype none
module nfz4_mul
    import nfz4_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [63:0] i_a,
    input  wire logic signed [63:0] i_b,
    output logic                    o_done,
    output logic [127:0]            o_p
);
    logic [63:0]  r_ma;
    logic [63:0]  r_mb;
    logic         r_neg;
    logic         r_busy;
    logic [2:0]   r_step;
    logic [127:0] r_acc;
    logic [31:0]  ah;
    logic [31:0]  bh;
    logic [63:0]  pp;
    logic [127:0] pp_sh;

    assign ah = r_step[1] ? r_ma[63:32] : r_ma[31:0];
    assign bh = r_step[0] ? r_mb[63:32] : r_mb[31:0];
    assign pp = ah * bh;

    always_comb begin
        case (r_step[1:0])
            2'd0:    pp_sh = {64'd0, pp};
            2'd3:    pp_sh = {pp, 64'd0};
            default: pp_sh = {32'd0, pp, 32'd0};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_ma   <= i_a[63] ? 64'd0 - i_a : i_a;
                r_mb   <= i_b[63] ? 64'd0 - i_b : i_b;
                r_neg  <= i_a[63] ^ i_b[63];
                r_acc  <= '0;
                r_step <= 3'd0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_step == 3'd4) begin
                    o_p    <= r_neg ? 128'd0 - r_acc : r_acc;
                    o_done <= 1'b1;
                    r_busy <= 1'b0;
                end else begin
                    r_acc  <= r_acc + pp_sh;
                    r_step <= r_step + 3'd1;
                end
            end
        end
    end
endmodule
`default_nettype wire

[src/nfz4_div.sv]
// Two-lane restoring divider: num * 2^56 / den truncated toward zero, one quotient bit per cycle.
`default_nettype none
module nfz4_div
    import nfz4_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [127:0] i_num_re,
    input  wire logic [127:0] i_num_im,
    input  wire logic [127:0] i_den,
    output logic              o_done,
    output logic signed [63:0] o_q_re,
    output logic signed [63:0] o_q_im
);
    localparam int QB = 63;

    logic [127:0] r_rem [2];
    logic [QB-1:0] r_sr [2];
    logic [QB-1:0] r_q  [2];
    logic          r_neg [2];
    logic          r_ovf [2];
    logic [127:0]  r_den;
    logic          r_busy;
    logic          r_fin;
    logic [5:0]    r_cnt;

    logic [127:0]  num  [2];
    logic [127:0]  mag  [2];
    logic [127:0]  rsh  [2];
    logic          ge   [2];
    logic signed [63:0] qo [2];

    always_comb begin
        num[0] = i_num_re;
        num[1] = i_num_im;
        for (int l = 0; l < 2; l++) begin
            mag[l] = num[l][127] ? 128'd0 - num[l] : num[l];
            rsh[l] = {r_rem[l][126:0], r_sr[l][QB-1]};
            ge[l]  = (rsh[l] >= r_den);
            if (r_ovf[l])
                qo[l] = r_neg[l] ? SMIN : SMAX;
            else
                qo[l] = r_neg[l] ? 64'sd0 - {1'b0, r_q[l]} : {1'b0, r_q[l]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            for (int l = 0; l < 2; l++) begin
                r_neg[l] <= num[l][127];
                r_rem[l] <= {7'd0, mag[l][127:7]};
                r_ovf[l] <= ({7'd0, mag[l][127:7]} >= i_den);
                r_sr[l]  <= {mag[l][6:0], 56'd0};
                r_q[l]   <= '0;
            end
        end else if (r_busy) begin
            for (int l = 0; l < 2; l++) begin
                r_rem[l] <= ge[l] ? rsh[l] - r_den : rsh[l];
                r_q[l]   <= {r_q[l][QB-2:0], ge[l]};
                r_sr[l]  <= {r_sr[l][QB-2:0], 1'b0};
            end
        end
        if (r_fin) begin
            o_q_re <= qo[0];
            o_q_im <= qo[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= r_fin;
            r_fin  <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(QB - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

[src/nfz4_engine.sv]
// Back end: Newton step sequencer over a shared multiplier and divider.
`default_nettype none
module nfz4_engine
    import nfz4_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  t_cfg      i_cfg,
    input  wire logic i_in_valid,
    input  t_pt       i_in_pt,
    output logic      o_in_pop,
    output logic      o_out_push,
    output t_res      o_out_res,
    input  wire logic i_out_full
);
    t_state r_state, n_state;
    logic [4:0] r_pc;
    logic       r_issued;
    logic [7:0] r_it;
    logic [1:0] r_k;
    logic signed [63:0] r_zr, r_zi, r_z2r, r_z2i, r_z3r, r_z3i;
    logic signed [63:0] r_fr, r_fi, r_dr, r_di, r_er, r_ei;
    logic [127:0] r_acc, r_den, r_nr, r_ni;
    t_res r_res;

    t_uop uop;
    logic signed [63:0] opa, opb, q_re, q_im;
    logic [127:0] mul_p, acc_n;
    logic mul_start, mul_done, div_start, div_done, seg;
    logic conv_hit, tol_hit, dzero, give_up;

    assign uop      = uop_rom(r_pc);
    assign conv_hit = r_acc < {40'd0, i_cfg.conv, 56'd0};
    assign tol_hit  = r_acc < {40'd0, i_cfg.tol, 56'd0};
    assign dzero    = (r_dr == 64'sd0) && (r_di == 64'sd0);
    assign give_up  = (r_it >= i_cfg.limit) || dzero;
    assign seg      = (r_state == S_EVAL1) || (r_state == S_NUM) || (r_state == S_EVAL2)
                   || (r_state == S_NORM) || (r_state == S_ROOT);
    assign o_out_res = r_res;

    nfz4_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (opa),
        .i_b     (opb),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    nfz4_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_num_re (r_nr),
        .i_num_im (r_ni),
        .i_den    (r_den),
        .o_done   (div_done),
        .o_q_re   (q_re),
        .o_q_im   (q_im)
    );

    always_comb begin
        case (uop.a)
            OP_ZR:   opa = r_zr;
            OP_ZI:   opa = r_zi;
            OP_Z2R:  opa = r_z2r;
            OP_Z2I:  opa = r_z2i;
            OP_Z3R:  opa = r_z3r;
            OP_Z3I:  opa = r_z3i;
            OP_FR:   opa = r_fr;
            OP_FI:   opa = r_fi;
            OP_DR:   opa = r_dr;
            OP_DI:   opa = r_di;
            OP_ER:   opa = r_er;
            OP_EI:   opa = r_ei;
            default: opa = r_zr;
        endcase
        case (uop.b)
            OP_ZR:   opb = r_zr;
            OP_ZI:   opb = r_zi;
            OP_FR:   opb = r_fr;
            OP_FI:   opb = r_fi;
            OP_DR:   opb = r_dr;
            OP_DI:   opb = r_di;
            OP_ER:   opb = r_er;
            OP_EI:   opb = r_ei;
            default: opb = r_zr;
        endcase
        case (uop.op)
            ACC_ADD: acc_n = r_acc + mul_p;
            ACC_SUB: acc_n = r_acc - mul_p;
            default: acc_n = mul_p;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_EVAL1;
            S_EVAL1: if (mul_done && uop.last) n_state = S_CHECK;
            S_CHECK: n_state = give_up ? S_DONE : S_NUM;
            S_NUM:   if (mul_done && uop.last) n_state = S_DIV;
            S_DIV:   if (div_done) n_state = S_EVAL2;
            S_EVAL2: if (mul_done && uop.last) n_state = S_NORM;
            S_NORM:  if (mul_done && uop.last) n_state = S_NCHK;
            S_NCHK:  n_state = conv_hit ? S_RSUB : S_CHECK;
            S_RSUB:  n_state = S_ROOT;
            S_ROOT:  if (mul_done && uop.last) n_state = S_RCHK;
            S_RCHK:  n_state = (tol_hit || r_k == 2'd3) ? S_DONE : S_RSUB;
            S_DONE:  if (!i_out_full) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_pop   = (r_state == S_IDLE) && i_in_valid;
        mul_start  = seg && !r_issued;
        div_start  = (r_state == S_DIV) && !r_issued;
        o_out_push = (r_state == S_DONE) && !i_out_full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_issued <= 1'b0;
            r_pc     <= PC_EVAL;
            r_it     <= '0;
            r_k      <= '0;
        end else begin
            r_state <= n_state;
            if (mul_start || div_start)
                r_issued <= 1'b1;
            else if (mul_done || div_done)
                r_issued <= 1'b0;

            if (n_state != r_state) begin
                case (n_state)
                    S_NUM:   r_pc <= PC_NUM;
                    S_NORM:  r_pc <= PC_NORM;
                    S_ROOT:  r_pc <= PC_ROOT;
                    default: r_pc <= PC_EVAL;
                endcase
            end else if (mul_done) begin
                r_pc <= r_pc + 5'd1;
            end

            if (o_in_pop) r_it <= '0;
            if (r_state == S_NCHK) begin
                if (conv_hit) r_k <= 2'd0;
                else          r_it <= r_it + 8'd1;
            end
            if (r_state == S_RCHK && !tol_hit) r_k <= r_k + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_pop) begin
            r_zr <= i_in_pt.re;
            r_zi <= i_in_pt.im;
        end
        if (mul_done) begin
            r_acc <= acc_n;
            case (uop.wb)
                WB_Z2R: r_z2r <= sat_q56(acc_n);
                WB_Z2I: r_z2i <= sat_q56(acc_n);
                WB_Z3R: r_z3r <= sat_q56(acc_n);
                WB_Z3I: r_z3i <= sat_q56(acc_n);
                WB_FR: begin
                    r_fr <= s_sub(sat_q56(acc_n), ONE_Q);
                    r_dr <= sat_x4(r_z3r);
                    r_di <= sat_x4(r_z3i);
                end
                WB_FI:  r_fi  <= sat_q56(acc_n);
                WB_DEN: r_den <= acc_n;
                WB_NR:  r_nr  <= acc_n;
                WB_NI:  r_ni  <= acc_n;
                default: ;
            endcase
        end
        if (r_state == S_DIV && div_done) begin
            r_zr <= s_sub(r_zr, q_re);
            r_zi <= s_sub(r_zi, q_im);
        end
        if (r_state == S_RSUB) begin
            r_er <= s_sub(r_zr, root_re(r_k));
            r_ei <= s_sub(r_zi, root_im(r_k));
        end
        // drop to "not found" on any exit without a root match
        if (r_state == S_CHECK && give_up) r_res <= '0;
        if (r_state == S_RCHK) begin
            if (tol_hit)
                r_res <= '{root_index: r_k, found: 1'b1, iteration_count: r_it + 8'd1};
            else if (r_k == 2'd3)
                r_res <= '0;
        end
    end
endmodule
`default_nettype wire

[src/newton_fractal_z4_pixel_core.sv]
// Top level of the z^4-1 Newton fractal pixel core: config, front, back end, result register.
// Work per point: N Newton steps, N from 0 to limit, then root matching against up to
//   four roots; each multiply runs on the shared 32x32 multiplier and each divide on the
//   two-lane one-bit-per-cycle divider.
// Throughput: one point at a time in the back end; a two-deep input queue and a result
//   register let both sides keep moving during the work.
// Reset: synchronous, active low; clears the queues and the sequencer, config to defaults.
`default_nettype none
module newton_fractal_z4_pixel_core
    import nfz4_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // input queue side
    input  wire logic               push,
    output logic                    full,
    input  wire logic signed [31:0] i_start_re,
    input  wire logic signed [31:0] i_start_im,
    // result queue side
    output logic                    empty,
    input  wire logic               pop,
    output logic [1:0]              o_root_index,
    output logic                    o_found,
    output logic [7:0]              o_iteration_count,
    // configuration writes
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_idx,
    input  wire logic [31:0]        i_cfg_data
);
    t_cfg r_cfg;
    logic r_out_valid;
    t_res r_out;

    logic q_valid;
    logic q_pop;
    t_pt  q_pt;
    logic res_push;
    t_res res;

    // The user must change registers only while the core is idle (not enforced here), so no shadow copy is kept.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{limit: LIMIT_RST, conv: CONV_RST, tol: TOL_RST};
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LIMIT: r_cfg.limit <= i_cfg_data[7:0];
                CFG_CONV:  r_cfg.conv  <= i_cfg_data;
                CFG_TOL:   r_cfg.tol   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Front: convert and hold start points until the back end takes them.
    nfz4_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_start_re (i_start_re),
        .i_start_im (i_start_im),
        .o_valid    (q_valid),
        .o_pt       (q_pt),
        .i_pop      (q_pop)
    );

    // Back: iterate, test convergence, match roots.
    nfz4_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (q_valid),
        .i_in_pt    (q_pt),
        .o_in_pop   (q_pop),
        .o_out_push (res_push),
        .o_out_res  (res),
        .i_out_full (r_out_valid)
    );

    // Result register: hold a finished transaction until the consumer pops it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_push) begin
            r_out_valid <= 1'b1;
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_push) r_out <= res;
    end

    assign empty             = !r_out_valid;
    assign o_root_index      = r_out.root_index;
    assign o_found           = r_out.found;
    assign o_iteration_count = r_out.iteration_count;
endmodule
`default_nettype wire

[src/nfz4_chk.sv]
// Port-level checker for the Newton pixel core, bound to the top level.
`default_nettype none
module nfz4_chk (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       pop,
    input wire logic       empty,
    input wire logic [1:0] o_root_index,
    input wire logic       o_found,
    input wire logic [7:0] o_iteration_count
);
    // a miss reports all fields zero
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_found) |-> (o_root_index == 2'd0 && o_iteration_count == 8'd0))
        else $error("miss result carries nonzero fields");

    // a hit took at least one step
    a_hit_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_found) |-> (o_iteration_count != 8'd0))
        else $error("hit result with zero iterations");

    // a waiting result holds until popped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_root_index) && $stable(o_found)
                              && $stable(o_iteration_count)))
        else $error("result changed while waiting");
endmodule

bind newton_fractal_z4_pixel_core nfz4_chk u_nfz4_chk (.*);
`default_nettype wire

[bench/newton_fractal_z4_pixel_core_tb.sv]
// Self-checking bench for the z^4-1 Newton fractal pixel core, with a fixed-point predictor.
`default_nettype none
module newton_fractal_z4_pixel_core_tb;
    import nfz4_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int      FRAC      = 28;
    localparam longint  CYCLE_CAP = 60_000_000;
    localparam int      ITEMS     = 1900;
    localparam int      HOLD_LEN  = 15000;
    localparam logic signed [31:0] ONE_IN = 32'sh1000_0000;

    logic               i_clk;
    logic               i_rst_n;
    logic               push;
    logic               full;
    logic signed [31:0] i_start_re;
    logic signed [31:0] i_start_im;
    logic               empty;
    logic               pop;
    logic [1:0]         o_root_index;
    logic               o_found;
    logic [7:0]         o_iteration_count;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_idx;
    logic [31:0]        i_cfg_data;

    newton_fractal_z4_pixel_core #(.FRAC_BITS(FRAC)) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_start_re        (i_start_re),
        .i_start_im        (i_start_im),
        .empty             (empty),
        .pop               (pop),
        .o_root_index      (o_root_index),
        .o_found           (o_found),
        .o_iteration_count (o_iteration_count),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data)
    );

    // Shadow copy of the configuration registers, tracked at the write port.
    logic [7:0]  lim_q;
    logic [31:0] conv_q;
    logic [31:0] tol_q;

    t_res   pending_pixels[$];
    int     errors;
    longint cycles;
    logic   hold_req;

    // Typed expectation for the directed row in flight, used instead of the predictor.
    logic   row_fixed;
    t_res   row_exp;

    //------------------------------------------------------------------------
    // Fixed-point predictor
    //------------------------------------------------------------------------

    // Clamp a wide signed value into the Q7.56 range.
    function automatic logic signed [63:0] clamp64(input logic signed [127:0] w);
        if ((&w[127:63]) || (~|w[127:63])) return w[63:0];
        return w[127] ? SMIN : SMAX;
    endfunction

    function automatic logic signed [63:0] qadd(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        logic signed [127:0] wa, wb;
        wa = a;
        wb = b;
        return clamp64(wa + wb);
    endfunction

    function automatic logic signed [63:0] qsub(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        logic signed [127:0] wa, wb;
        wa = a;
        wb = b;
        return clamp64(wa - wb);
    endfunction

    // Exact 128-bit product of two Q7.56 values.
    function automatic logic signed [127:0] wmul(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
        logic signed [127:0] wa, wb;
        wa = a;
        wb = b;
        return wa * wb;
    endfunction

    function automatic logic signed [127:0] mag2(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
        return wmul(a, a) + wmul(b, b);
    endfunction

    // Complex multiply: exact cross sums, floor shift by 56, then clamp.
    function automatic void cplx_mul(input logic signed [63:0] ar, input logic signed [63:0] ai,
                                     input logic signed [63:0] br, input logic signed [63:0] bi,
                                     output logic signed [63:0] pr,
                                     output logic signed [63:0] pi);
        pr = clamp64((wmul(ar, br) - wmul(ai, bi)) >>> 56);
        pi = clamp64((wmul(ar, bi) + wmul(ai, br)) >>> 56);
    endfunction

    // num * 2^56 / den, truncated toward zero, clamped; den is always positive.
    function automatic logic signed [63:0] quot56(input logic signed [127:0] num,
                                                  input logic signed [127:0] den);
        logic [127:0] mg;
        logic [191:0] q;
        mg = num[127] ? (~num + 128'd1) : num;
        q  = {mg, 56'd0} / {64'd0, den};
        if (q >= {128'd0, 64'h8000_0000_0000_0000}) return num[127] ? SMIN : SMAX;
        return num[127] ? -$signed(q[63:0]) : $signed(q[63:0]);
    endfunction

    // f(z) = z^4 - 1 and f'(z) = 4 z^3, the latter as two saturating doublings.
    function automatic void poly_eval(input logic signed [63:0] zr, input logic signed [63:0] zi,
                                      output logic signed [63:0] fr,
                                      output logic signed [63:0] fi,
                                      output logic signed [63:0] dr,
                                      output logic signed [63:0] di);
        logic signed [63:0] z2r, z2i, z3r, z3i, z4r, z4i;
        cplx_mul(zr, zi, zr, zi, z2r, z2i);
        cplx_mul(z2r, z2i, zr, zi, z3r, z3i);
        cplx_mul(z3r, z3i, zr, zi, z4r, z4i);
        fr = qsub(z4r, ONE_Q);
        fi = z4i;
        dr = qadd(qadd(z3r, z3r), qadd(z3r, z3r));
        di = qadd(qadd(z3i, z3i), qadd(z3i, z3i));
    endfunction

    function automatic t_res newton_pixel_predict(input logic signed [31:0] sre,
                                                  input logic signed [31:0] sim,
                                                  input logic [7:0] lim,
                                                  input logic [31:0] conv,
                                                  input logic [31:0] tol);
        t_res r;
        logic signed [63:0]  zr, zi, fr, fi, dr, di, rr, ri;
        logic signed [127:0] den, cbound, tbound, w;
        int it;
        int k;
        logic done;
        r      = '0;
        done   = 1'b0;
        w      = sre;
        zr     = clamp64(w <<< (IFRAC - FRAC));
        w      = sim;
        zi     = clamp64(w <<< (IFRAC - FRAC));
        cbound = {64'd0, conv} << IFRAC;
        tbound = {64'd0, tol} << IFRAC;
        for (it = 0; it < lim && !done; it++) begin
            poly_eval(zr, zi, fr, fi, dr, di);
            if (dr == 0 && di == 0) begin
                done = 1'b1;
            end else begin
                den = mag2(dr, di);
                zr  = qsub(zr, quot56(wmul(fr, dr) + wmul(fi, di), den));
                zi  = qsub(zi, quot56(wmul(fi, dr) - wmul(fr, di), den));
                poly_eval(zr, zi, fr, fi, dr, di);
                // squared magnitudes are unsigned 128-bit quantities
                if ($unsigned(mag2(fr, fi)) < $unsigned(cbound)) begin
                    done = 1'b1;
                    for (k = 0; k < 4 && !r.found; k++) begin
                        rr = (k == 0) ? ONE_Q : (k == 1) ? -ONE_Q : 64'sd0;
                        ri = (k == 2) ? ONE_Q : (k == 3) ? -ONE_Q : 64'sd0;
                        if ($unsigned(mag2(qsub(zr, rr), qsub(zi, ri)))
                            < $unsigned(tbound)) begin
                            r.root_index      = k[1:0];
                            r.found           = 1'b1;
                            r.iteration_count = 8'(it + 1);
                        end
                    end
                end
            end
        end
        return r;
    endfunction

    //------------------------------------------------------------------------
    // Clock, cycle cap
    //------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    //------------------------------------------------------------------------
    // Monitor: track config writes, predict on every accepted point, check
    // every popped result against the oldest expectation.
    //------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_LIMIT: lim_q  = i_cfg_data[7:0];
                    CFG_CONV:  conv_q = i_cfg_data;
                    CFG_TOL:   tol_q  = i_cfg_data;
                    default: ;
                endcase
            end
            if (push && !full) begin
                if (row_fixed)
                    pending_pixels = {pending_pixels, row_exp};
                else
                    pending_pixels = {pending_pixels,
                                      newton_pixel_predict(i_start_re, i_start_im,
                                                           lim_q, conv_q, tol_q)};
            end
            if (pop && !empty) begin
                got = '{o_root_index, o_found, o_iteration_count};
                if (pending_pixels.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result transaction %p", $realtime, got);
                end else begin
                    want = pending_pixels.pop_front();
                    if (got.root_index !== want.root_index) begin
                        errors++;
                        $display("%0t: root_index expected %0d actual %0d",
                                 $realtime, want.root_index, got.root_index);
                    end
                    if (got.found !== want.found) begin
                        errors++;
                        $display("%0t: found expected %0d actual %0d",
                                 $realtime, want.found, got.found);
                    end
                    if (got.iteration_count !== want.iteration_count) begin
                        errors++;
                        $display("%0t: iteration_count expected %0d actual %0d",
                                 $realtime, want.iteration_count, got.iteration_count);
                    end
                end
            end
        end
    end

    //------------------------------------------------------------------------
    // Receiver: pop with random gaps; on request hold off for a long stretch
    // so the input queue fills and full rises.
    //------------------------------------------------------------------------
    initial begin
        int r;
        int n;
        pop = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                pop <= 1'b0;
                repeat (HOLD_LEN) @(negedge i_clk);
                pop <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 75) begin
                    pop <= 1'b1;
                end else begin
                    pop <= 1'b0;
                    n = (r < 96) ? $urandom_range(1, 5) : $urandom_range(30, 300);
                    repeat (n) @(negedge i_clk);
                    pop <= 1'b1;
                end
            end
        end
    end

    //------------------------------------------------------------------------
    // Sender
    //------------------------------------------------------------------------

    // Offer one point; push stays high after acceptance so back-to-back
    // transactions never lower and raise it in the same step. A typed
    // expectation, when given, travels with the point.
    task automatic offer_point(input logic signed [31:0] re, input logic signed [31:0] im,
                               input logic fixed = 1'b0, input t_res want = '0);
        @(negedge i_clk);
        row_fixed  = fixed;
        row_exp    = want;
        push       <= 1'b1;
        i_start_re <= re;
        i_start_im <= im;
        do @(posedge i_clk); while (full);
    endtask

    task automatic sender_gap();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r >= 65) begin
            n = (r < 95) ? $urandom_range(1, 6) : $urandom_range(40, 500);
            @(negedge i_clk);
            push <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    // Stop offering and wait for every outstanding transaction to drain.
    task automatic drain();
        @(negedge i_clk);
        push <= 1'b0;
        while (pending_pixels.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic apply_cfg(input logic [7:0] lim, input logic [31:0] conv,
                             input logic [31:0] tol);
        write_reg(CFG_LIMIT, {24'd0, lim});
        write_reg(CFG_CONV, conv);
        write_reg(CFG_TOL, tol);
    endtask

    // Mostly points within |re|,|im| <= 2, some just off a root, some anywhere.
    task automatic random_point(output logic signed [31:0] re, output logic signed [31:0] im);
        int r;
        int k;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            re = $signed($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000;
            im = $signed($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000;
        end else if (r < 85) begin
            k  = $urandom_range(0, 3);
            re = (k == 0) ? ONE_IN : (k == 1) ? -ONE_IN : 32'sd0;
            im = (k == 2) ? ONE_IN : (k == 3) ? -ONE_IN : 32'sd0;
            re = re + $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
            im = im + $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
        end else begin
            re = $urandom;
            im = $urandom;
        end
    endtask

    typedef struct {
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic               fixed;
        t_res               res;
    } t_row;

    // Directed points, run at the reset configuration.
    t_row dir_rows[] = '{
        '{32'sd0,        32'sd0,        1'b1, '{2'd0, 1'b0, 8'd0}}, // derivative zero at origin
        '{ONE_IN,        32'sd0,        1'b1, '{2'd0, 1'b1, 8'd1}}, // exactly on root 1
        '{-ONE_IN,       32'sd0,        1'b1, '{2'd1, 1'b1, 8'd1}}, // exactly on root -1
        '{32'sd0,        ONE_IN,        1'b1, '{2'd2, 1'b1, 8'd1}}, // exactly on root i
        '{32'sd0,        -ONE_IN,       1'b1, '{2'd3, 1'b1, 8'd1}}, // exactly on root -i
        '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0, '0},
        '{32'sh8000_0000, 32'sh8000_0000, 1'b0, '0},
        '{32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0, '0},
        '{32'sh8000_0000, 32'sd0,        1'b0, '0},
        '{32'sd0,        32'sh7FFF_FFFF, 1'b0, '0},
        '{32'sd1,        32'sd0,        1'b0, '0},  // tiny start, cube underflows
        '{32'sd1,        32'sd1,        1'b0, '0},
        '{-32'sd1,       -32'sd1,       1'b0, '0},
        '{ONE_IN,        ONE_IN,        1'b0, '0},  // on a basin boundary
        '{32'sh1000_0005, 32'sd3,       1'b0, '0},
        '{32'sh0C00_0000, -32'sh0A00_0000, 1'b0, '0},
        '{32'sh5555_5555, 32'shAAAA_AAAA, 1'b0, '0},
        '{32'shAAAA_AAAA, 32'sh5555_5555, 1'b0, '0}
    };

    initial begin
        logic signed [31:0] re, im;
        logic [7:0]  lim;
        logic [31:0] conv, tol;
        int sent;
        int n;
        int i;
        errors     = 0;
        cycles     = 0;
        hold_req   = 1'b0;
        row_fixed  = 1'b0;
        row_exp    = '0;
        lim_q      = LIMIT_RST;
        conv_q     = CONV_RST;
        tol_q      = TOL_RST;
        push       = 1'b0;
        i_start_re = '0;
        i_start_im = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        i_rst_n    = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed rows at reset values; typed expectations where obvious.
        foreach (dir_rows[i]) begin
            offer_point(dir_rows[i].re, dir_rows[i].im, dir_rows[i].fixed, dir_rows[i].res);
            sender_gap();
        end
        drain();
        row_fixed = 1'b0;
        sent = dir_rows.size();

        // Register extremes. Limit one with loose bounds: fast pixels, so the
        // long receiver hold-off backs the input queue up.
        apply_cfg(8'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        hold_req = 1'b1;
        for (i = 0; i < 100; i++) begin
            random_point(re, im);
            offer_point(re, im);
        end
        drain();
        sent += 100;

        // Deepest limit, few points.
        apply_cfg(8'd255, 32'd16, 32'd16);
        for (i = 0; i < 8; i++) begin
            random_point(re, im);
            offer_point(re, im);
            sender_gap();
        end
        drain();
        sent += 8;

        // Zero threshold never converges; zero tolerance never matches.
        apply_cfg(8'd12, 32'd0, 32'hFFFF_FFFF);
        for (i = 0; i < 40; i++) begin
            random_point(re, im);
            offer_point(re, im);
            sender_gap();
        end
        drain();
        apply_cfg(8'd20, 32'hFFFF_FFFF, 32'd0);
        for (i = 0; i < 60; i++) begin
            random_point(re, im);
            offer_point(re, im);
            sender_gap();
        end
        drain();
        sent += 100;

        // Random phases with random settings, draining between them.
        while (sent < ITEMS) begin
            lim  = $urandom_range(2, 30);
            conv = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 4096);
            tol  = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 4096);
            apply_cfg(lim, conv, tol);
            n = $urandom_range(80, 200);
            for (i = 0; i < n; i++) begin
                random_point(re, im);
                offer_point(re, im);
                sender_gap();
            end
            drain();
            sent += n;
        end

        repeat (300) @(negedge i_clk);
        if (errors == 0 && pending_pixels.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire
